FILE: sv/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared widths, constants, types and the BCD digit correction for the
// binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

	// Field widths
	localparam int VALUE_W     = 32;
	localparam int START_W     = 8;
	localparam int CHAR_W      = 6;
	localparam int INDEX_W     = 8;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 16;

	// BCD working register: ten digits cover any 32-bit value
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int DIG_IDX_W  = 4;
	localparam int ITER_W     = 5;

	localparam logic [ITER_W-1:0] LAST_ITER  = ITER_W'(VALUE_W - 1);
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	// Converter to emitter: conversion finished, digits valid this cycle
	typedef struct packed {
		logic             done;
		logic [BCD_W-1:0] bcd;
	} cvt_t;

	// Double-dabble correction: a digit of five or more gets three added
	function automatic logic [3:0] add3(input logic [3:0] d);
		logic [3:0] r;
		if (d >= 4'd5) begin
			r = d + 4'd3;
		end else begin
			r = d;
		end
		return r;
	endfunction

endpackage

FILE: sv/b2da_dabble.sv
// ----------------------------------------------------------------------------
// b2da_dabble
// Iterative binary to BCD converter: one shift-add-3 step per cycle over
// the ten-digit BCD register, 32 steps per value.
// ----------------------------------------------------------------------------
module b2da_dabble (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [b2da_pkg::VALUE_W-1:0] value,
	output b2da_pkg::cvt_t               cvt
);

	logic                          busy_q;
	logic                          done_q;
	logic [b2da_pkg::ITER_W-1:0]   cnt_q;
	logic [b2da_pkg::VALUE_W-1:0]  bin_q;
	logic [b2da_pkg::BCD_W-1:0]    bcd_q;
	logic [b2da_pkg::BCD_W-1:0]    corr;

	// Correct every digit before the shift
	always_comb begin
		for (int i = 0; i < b2da_pkg::BCD_DIGITS; i++) begin
			corr[4*i +: 4] = b2da_pkg::add3(bcd_q[4*i +: 4]);
		end
	end

	// Sequencer: step counter and busy / done flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == b2da_pkg::LAST_ITER);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == b2da_pkg::LAST_ITER) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Shared shift unit: binary msb moves into the corrected BCD word
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {corr[b2da_pkg::BCD_W-2:0], bin_q[b2da_pkg::VALUE_W-1]};
			bin_q <= {bin_q[b2da_pkg::VALUE_W-2:0], 1'b0};
		end
	end

	assign cvt.done = done_q;
	assign cvt.bcd  = bcd_q;

endmodule

FILE: sv/b2da_emit.sv
// ----------------------------------------------------------------------------
// b2da_emit
// Digit emitter: reduces the start position modulo the buffer depth while
// the conversion runs, then sends one ASCII digit per cycle while out_ready
// does not stall it, most significant first, through an output register.
// ----------------------------------------------------------------------------
module b2da_emit #(
	parameter int MAX_DIGITS   = 10,
	parameter int BUFFER_DEPTH = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [b2da_pkg::START_W-1:0] start_index,
	input  b2da_pkg::cvt_t               cvt,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [b2da_pkg::CHAR_W-1:0]  char_code,
	output logic [b2da_pkg::INDEX_W-1:0] write_index,
	output logic                         wrapped,
	output logic                         last,
	output logic                         idle
);

	localparam int EMIT_MAX = (MAX_DIGITS < b2da_pkg::BCD_DIGITS) ? MAX_DIGITS
	                                                             : b2da_pkg::BCD_DIGITS;
	localparam int DW = $clog2(BUFFER_DEPTH);
	localparam int PW = (DW > b2da_pkg::INDEX_W) ? DW : b2da_pkg::INDEX_W;
	localparam int CW = PW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
	localparam logic [b2da_pkg::DIG_IDX_W-1:0] TOP_IDX = b2da_pkg::DIG_IDX_W'(EMIT_MAX - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WAIT = 2'd1;
	localparam logic [1:0] ST_SEND = 2'd2;

	logic [1:0]                         state_q;
	logic [b2da_pkg::DIG_IDX_W-1:0]     dig_q;
	logic [b2da_pkg::BCD_W-1:0]         bcd_q;
	logic [PW-1:0]                      pos_q;
	logic [CW-1:0]                      raw_q;
	logic                               vld_q;
	logic [b2da_pkg::CHAR_W-1:0]        char_q;
	logic [b2da_pkg::INDEX_W-1:0]       idx_q;
	logic                               wrap_q;
	logic                               last_q;

	logic [b2da_pkg::DIG_IDX_W-1:0]     msd;
	logic [b2da_pkg::DIG_IDX_W-1:0]     first_idx;
	logic [3:0]                         digit;
	logic [CW-1:0]                      pos_inc;
	logic                               issue;

	// Most significant nonzero digit of the fresh conversion
	always_comb begin
		msd = '0;
		for (int i = 0; i < b2da_pkg::BCD_DIGITS; i++) begin
			if (cvt.bcd[4*i +: 4] != 4'd0) begin
				msd = b2da_pkg::DIG_IDX_W'(i);
			end
		end
		first_idx = (msd > TOP_IDX) ? TOP_IDX : msd;
	end

	assign digit   = bcd_q[4*dig_q +: 4];
	assign pos_inc = {1'b0, pos_q} + 1'b1;
	assign issue   = (state_q == ST_SEND) && (!vld_q || out_ready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (load) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (cvt.done) begin
						state_q <= ST_SEND;
					end
				end
				ST_SEND: begin
					if (issue && (dig_q == '0)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Position tracking and digit pointer
	always_ff @(posedge clk) begin
		if (load) begin
			pos_q <= PW'(start_index);
			raw_q <= CW'(start_index);
		end else if (state_q == ST_WAIT) begin
			// repeated subtraction of the buffer depth while the conversion runs
			if ({1'b0, pos_q} >= DEPTH_C) begin
				pos_q <= PW'({1'b0, pos_q} - DEPTH_C);
			end
		end else if (issue) begin
			pos_q <= (pos_inc == DEPTH_C) ? '0 : pos_inc[PW-1:0];
			raw_q <= raw_q + 1'b1;
		end
		if (state_q == ST_WAIT && cvt.done) begin
			bcd_q <= cvt.bcd;
			dig_q <= first_idx;
		end else if (issue) begin
			dig_q <= dig_q - 1'b1;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (issue) begin
			vld_q <= 1'b1;
		end else if (out_ready) begin
			vld_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (issue) begin
			char_q <= b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(digit);
			idx_q  <= pos_q[b2da_pkg::INDEX_W-1:0];
			wrap_q <= (raw_q >= DEPTH_C);
			last_q <= (dig_q == '0);
		end
	end

	assign out_valid   = vld_q;
	assign char_code   = char_q;
	assign write_index = idx_q;
	assign wrapped     = wrap_q;
	assign last        = last_q;
	assign idle        = (state_q == ST_IDLE);

endmodule

FILE: sv/binary_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// Converts a 32-bit unsigned value to decimal ASCII digits, most significant
// first without leading zeros, each tagged with its buffer position.
//
//   channel  | dir | tdata fields (lsb up)                    | tuser | tlast
//   s_*      | in  | value[31:0], start_index[39:32]          | -     | -
//   m_*      | out | char_code[5:0], write_index[13:6],       | -     | last digit
//            |     | wrapped[14], zero[15]                    |       |
//
// Each request runs 32 shift-add-3 steps in the shared BCD unit between
// its load and hand-over, then its digits leave one per cycle while the
// output is not stalled.
// s_tready is high only while no request is being converted or emitted; the
// last digit may still wait in the output register when the next is taken.
// A stall on m_tready holds the output register and pauses digit emission.
// Reset clears the sequencers and output valid; nothing else is held.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_core #(
	parameter int MAX_DIGITS   = 10,
	parameter int BUFFER_DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [b2da_pkg::IN_TDATA_W-1:0]  s_tdata,   // value, start_index
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [b2da_pkg::OUT_TDATA_W-1:0] m_tdata,   // char_code, write_index, wrapped
	output logic                             m_tlast
);

	logic                         accept;
	logic                         idle;
	b2da_pkg::cvt_t               cvt;
	logic [b2da_pkg::CHAR_W-1:0]  char_code;
	logic [b2da_pkg::INDEX_W-1:0] write_index;
	logic                         wrapped;

	assign s_tready = idle;
	assign accept   = s_tvalid && idle;

	// Shared shift-add-3 converter
	b2da_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.value  (s_tdata[b2da_pkg::VALUE_W-1:0]),
		.cvt    (cvt)
	);

	// Digit sequencer and output register
	b2da_emit #(
		.MAX_DIGITS   (MAX_DIGITS),
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.start_index (s_tdata[b2da_pkg::VALUE_W +: b2da_pkg::START_W]),
		.cvt         (cvt),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.char_code   (char_code),
		.write_index (write_index),
		.wrapped     (wrapped),
		.last        (m_tlast),
		.idle        (idle)
	);

	assign m_tdata = {1'b0, wrapped, write_index, char_code};

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for binary_to_decimal_ascii_core. Every accepted
// request is turned into its expected digit stream (ASCII code, buffer
// position, wrap flag and last mark) and each digit that leaves the core
// is compared in order. Directed corner values come first, then a long
// receiver hold-off with back-to-back requests, then random requests with
// random idling on both sides that dies away towards the end.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int MAX_DIGITS   = 10;
	localparam int BUFFER_DEPTH = 256;
	localparam int DIGIT_SLOTS  = 20;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 60;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int N_RANDOM     = 85;
	localparam int N_QUIET      = 15;
	localparam int MAX_REPORTS  = 10;

	// One emitted digit as it should appear on the output
	typedef struct packed {
		logic [b2da_pkg::CHAR_W-1:0]  char_code;
		logic [b2da_pkg::INDEX_W-1:0] write_index;
		logic                         wrapped;
		logic                         last;
	} digit_t;

	// Expected digit store and comparison
	class digit_scoreboard;
		digit_t pending_digits[$];
		int     errors = 0;

		function void fail_note(string msg);
			errors++;
			if (errors <= MAX_REPORTS) begin
				$display("%0t: %s", $time, msg);
			end
		endfunction

		function int pending();
			return pending_digits.size();
		endfunction

		// Decimal expansion of one accepted request
		function void note_request(input logic [b2da_pkg::VALUE_W-1:0] value,
				input logic [b2da_pkg::START_W-1:0] start);
			logic [3:0]      dec [DIGIT_SLOTS];
			longint unsigned v;
			int              n_dig;
			int              n_emit;
			int unsigned     pos_raw;
			digit_t          d;
			v = 64'(value);
			n_dig = 1;
			while (v >= 10) begin
				v = v / 10;
				n_dig++;
			end
			n_emit = (n_dig > MAX_DIGITS) ? MAX_DIGITS : n_dig;
			// least significant digit goes in the last emitted slot
			v = 64'(value);
			for (int k = n_emit - 1; k >= 0; k--) begin
				dec[k] = 4'(v % 10);
				v = v / 10;
			end
			for (int k = 0; k < n_emit; k++) begin
				pos_raw = start + k;
				d.char_code   = b2da_pkg::CHAR_W'(b2da_pkg::ASCII_ZERO + dec[k]);
				d.write_index = b2da_pkg::INDEX_W'(pos_raw % BUFFER_DEPTH);
				d.wrapped     = (pos_raw >= BUFFER_DEPTH);
				d.last        = (k == n_emit - 1);
				pending_digits.push_back(d);
			end
		endfunction

		function void check_digit(input logic [b2da_pkg::OUT_TDATA_W-1:0] data,
				input logic tlast);
			digit_t got;
			digit_t exp_d;
			got.char_code   = data[b2da_pkg::CHAR_W-1:0];
			got.write_index = data[b2da_pkg::CHAR_W+b2da_pkg::INDEX_W-1:b2da_pkg::CHAR_W];
			got.wrapped     = data[b2da_pkg::CHAR_W+b2da_pkg::INDEX_W];
			got.last        = tlast;
			if (pending_digits.size() == 0) begin
				fail_note($sformatf("unexpected digit: %0d idx %0d wrap %0b last %0b",
					got.char_code, got.write_index, got.wrapped, got.last));
			end else begin
				exp_d = pending_digits.pop_front();
				if (got !== exp_d || data[b2da_pkg::OUT_TDATA_W-1] !== 1'b0) begin
					fail_note($sformatf(
						"exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b pad %0b",
						exp_d.char_code, exp_d.write_index, exp_d.wrapped, exp_d.last,
						got.char_code, got.write_index, got.wrapped, got.last,
						data[b2da_pkg::OUT_TDATA_W-1]));
				end
			end
		endfunction

		// Anything still waiting at the end never arrived
		function void flush_leftovers();
			while (pending_digits.size() != 0) begin
				void'(pending_digits.pop_front());
				fail_note("expected digit never arrived");
			end
		endfunction
	endclass

	logic                             clk      = 1'b0;
	logic                             arst_n   = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [b2da_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [b2da_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                             m_tlast;

	bit quiet    = 1'b0;
	bit hold_req = 1'b0;

	digit_scoreboard sb = new();

	// Clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	binary_to_decimal_ascii_core #(
		.MAX_DIGITS  (MAX_DIGITS),
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	// Offer one request, maybe after an idle burst, and wait for it to be taken
	task automatic send_request(input logic [b2da_pkg::VALUE_W-1:0] value,
			input logic [b2da_pkg::START_W-1:0] start);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {start, value};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request(value, start);
	endtask

	// Output side: random back-pressure, long hold-off on demand
	initial begin
		int n;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (quiet) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 15);
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				n = $urandom_range(1, 20);
				m_tready <= 1'b1;
				repeat (n) @(posedge clk);
			end
		end
	end

	// Output monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_digit(m_tdata, m_tlast);
		end
	end

	// Stimulus
	initial begin
		longint unsigned lo;
		longint unsigned hi;
		logic [b2da_pkg::VALUE_W-1:0] value;
		logic [b2da_pkg::START_W-1:0] start;
		int d;
		int n;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero, extremes, digit-count boundaries, wrapping
		send_request(32'd0, 8'd0);
		send_request(32'd0, 8'd255);
		send_request(32'hFFFF_FFFF, 8'd0);
		send_request(32'hFFFF_FFFF, 8'd255);
		send_request(32'hFFFF_FFFF, 8'd250);
		send_request(32'd4294967295, 8'd246);
		send_request(32'd1000000000, 8'd247);
		send_request(32'd999999999, 8'd128);
		send_request(32'd1, 8'd1);
		send_request(32'd9, 8'd254);
		send_request(32'd10, 8'd255);
		send_request(32'd99, 8'd17);
		send_request(32'd100, 8'd253);
		send_request(32'd12345, 8'd64);
		send_request(32'hAAAA_AAAA, 8'h55);
		send_request(32'h5555_5555, 8'hAA);
		send_request(32'h8000_0000, 8'h80);
		send_request(32'h7FFF_FFFF, 8'h7F);
		send_request(32'd1000, 8'd252);
		send_request(32'd90000001, 8'd3);

		// long output stall while requests keep coming, then drain fully
		hold_req = 1'b1;
		repeat (5) send_request($urandom(), 8'($urandom_range(0, 255)));
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);

		// random part; idling stops for the final stretch
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i >= N_RANDOM - N_QUIET) begin
				quiet = 1'b1;
			end
			if ($urandom_range(0, 4) == 0) begin
				value = $urandom();
			end else begin
				// spread over digit counts
				d = $urandom_range(1, 10);
				lo = 1;
				repeat (d - 1) lo = lo * 10;
				hi = lo * 10 - 1;
				if (d == 1) begin
					lo = 0;
				end
				if (hi > 64'hFFFF_FFFF) begin
					hi = 64'hFFFF_FFFF;
				end
				value = $urandom_range(32'(hi), 32'(lo));
			end
			if ($urandom_range(0, 3) == 0) begin
				start = b2da_pkg::START_W'($urandom_range(246, 255));
			end else begin
				start = b2da_pkg::START_W'($urandom_range(0, 255));
			end
			send_request(value, start);
		end
		s_tvalid <= 1'b0;

		// drain, then let any stray digit show up
		n = 0;
		while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.flush_leftovers();
		if (sb.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
